// ----- hdl/hse_pkg.sv -----
// shared types and constants of the heap sort engine
package hse_pkg;

  localparam int unsigned ValW = 32;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_BLD_LOAD,
    ST_BLD_VAL,
    ST_SIFT,
    ST_X_LOAD,
    ST_X_SWAP,
    ST_OUT_RD,
    ST_OUT_PUSH
  } state_e;

  typedef enum logic [1:0] {
    SEL_NODE,
    SEL_LEFT,
    SEL_RIGHT
  } child_sel_e;

  typedef struct packed {
    logic            overflow;
    logic            last;
    logic [ValW-1:0] value;
  } res_t;

endpackage

// ----- hdl/heap_sort_engine.sv -----
// heap sort engine top level: run collection, heap build, extraction and output
// Collects a run of signed 32-bit values (tlast marks the final one) into a heap
// memory of CAPACITY entries, builds a max heap, extracts it and returns the run in
// ascending order with tlast on the final result; tuser is set on every result of a
// run that held more than CAPACITY values, the excess being dropped. Input takes one
// transaction per cycle while collecting and none from the end of a run until its
// final result is handed to the output register. The build and the extraction sift
// down the heap level by level on the dual-read, single-write heap memory, and each
// result is read from the heap memory and then pushed to the output register.
module heap_sort_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [hse_pkg::ValW-1:0]  s_axis_tdata_i,  // value
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [hse_pkg::ValW-1:0]  m_axis_tdata_o,  // sorted_value
  output logic                      m_axis_tlast_o,
  output logic [0:0]                m_axis_tuser_o   // overflow
);
  import hse_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  logic [CW-1:0]   cnt_q, cnt_d;
  logic            drop_q, drop_d;
  logic [CW-1:0]   bld_q, bld_d;
  logic [CW-1:0]   size_q, size_d;
  logic [AW-1:0]   node_q, node_d;
  logic [AW-1:0]   k_q, k_d;
  logic [ValW-1:0] v_q, v_d;
  logic            xphase_q, xphase_d;

  logic [ValW-1:0] mem [CAPACITY];
  logic            we;
  logic [AW-1:0]   wa, ra, rb;
  logic [ValW-1:0] wd, rd_a_q, rd_b_q;

  logic            in_acc;
  logic [CW-1:0]   cnt_new;
  logic [AW+1:0]   lidx, ridx, nlidx;
  logic            lval, rval;
  logic [ValW-1:0] bigv;
  child_sel_e      bsel;
  logic [AW-1:0]   nnode, bnode;
  logic            is_last_out;
  logic            out_free, out_push;
  res_t            out_res;

  assign s_axis_tready_o = (state_q == ST_COLLECT);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_new = (cnt_q < CW'(CAPACITY)) ? cnt_q + CW'(1) : cnt_q;

  // sift comparison at the current node
  assign lidx = {1'b0, node_q, 1'b1};
  assign ridx = lidx + (AW+2)'(1);
  assign lval = lidx < (AW+2)'(size_q);
  assign rval = ridx < (AW+2)'(size_q);

  always_comb begin
    bigv = v_q;
    bsel = SEL_NODE;
    if (lval && ($signed(v_q) < $signed(rd_a_q))) begin
      bigv = rd_a_q;
      bsel = SEL_LEFT;
    end
    if (rval && ($signed(bigv) < $signed(rd_b_q))) begin
      bigv = rd_b_q;
      bsel = SEL_RIGHT;
    end
  end

  assign bnode = (bsel == SEL_RIGHT) ? ridx[AW-1:0] : lidx[AW-1:0];
  assign nlidx = {1'b0, bnode, 1'b1};
  assign nnode = AW'(bld_q - CW'(1));
  assign is_last_out = (CW'(k_q) + CW'(1)) == cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_acc && s_axis_tlast_i) begin
          state_d = (cnt_new > CW'(1)) ? ST_BLD_LOAD : ST_OUT_RD;
        end
      end
      ST_BLD_LOAD: state_d = ST_BLD_VAL;
      ST_BLD_VAL:  state_d = ST_SIFT;
      ST_SIFT: begin
        if (bsel == SEL_NODE) begin
          if (!xphase_q) begin
            state_d = (bld_q == CW'(1)) ? ST_X_LOAD : ST_BLD_LOAD;
          end else begin
            state_d = (size_q > CW'(1)) ? ST_X_LOAD : ST_OUT_RD;
          end
        end
      end
      ST_X_LOAD:   state_d = ST_X_SWAP;
      ST_X_SWAP:   state_d = ST_SIFT;
      ST_OUT_RD:   state_d = ST_OUT_PUSH;
      ST_OUT_PUSH: begin
        if (out_free) begin
          state_d = is_last_out ? ST_COLLECT : ST_OUT_RD;
        end
      end
      default:     state_d = ST_COLLECT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    bld_d    = bld_q;
    size_d   = size_q;
    node_d   = node_q;
    k_d      = k_q;
    v_d      = v_q;
    xphase_d = xphase_q;
    we       = 1'b0;
    wa       = '0;
    wd       = '0;
    ra       = '0;
    rb       = '0;
    out_push = 1'b0;
    out_res  = '0;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_acc) begin
          if (cnt_q < CW'(CAPACITY)) begin
            we = 1'b1;
            wa = cnt_q[AW-1:0];
            wd = s_axis_tdata_i;
          end else begin
            drop_d = 1'b1;
          end
          cnt_d = cnt_new;
          if (s_axis_tlast_i) begin
            size_d   = cnt_new;
            bld_d    = cnt_new >> 1;
            k_d      = '0;
            xphase_d = 1'b0;
          end
        end
      end
      ST_BLD_LOAD: begin
        ra = nnode;
      end
      ST_BLD_VAL: begin
        v_d    = rd_a_q;
        node_d = nnode;
        ra     = AW'({nnode, 1'b1});
        rb     = AW'({nnode, 1'b1} + (AW+1)'(1));
      end
      ST_SIFT: begin
        we = 1'b1;
        wa = node_q;
        if (bsel == SEL_NODE) begin
          wd = v_q;
          if (!xphase_q) begin
            bld_d = bld_q - CW'(1);
            if (bld_q == CW'(1)) begin
              xphase_d = 1'b1;
            end
          end
        end else begin
          wd     = bigv;
          node_d = bnode;
          ra     = nlidx[AW-1:0];
          rb     = AW'(nlidx + (AW+2)'(1));
        end
      end
      ST_X_LOAD: begin
        ra = '0;
        rb = AW'(size_q - CW'(1));
      end
      ST_X_SWAP: begin
        we     = 1'b1;
        wa     = AW'(size_q - CW'(1));
        wd     = rd_a_q;
        v_d    = rd_b_q;
        size_d = size_q - CW'(1);
        node_d = '0;
        ra     = AW'(1);
        rb     = AW'(2);
      end
      ST_OUT_RD: begin
        ra = k_q;
      end
      ST_OUT_PUSH: begin
        ra = k_q;
        if (out_free) begin
          out_push         = 1'b1;
          out_res.value    = rd_a_q;
          out_res.last     = is_last_out;
          out_res.overflow = drop_q;
          k_d              = k_q + AW'(1);
          if (is_last_out) begin
            cnt_d  = '0;
            drop_d = 1'b0;
          end
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_COLLECT;
      cnt_q    <= '0;
      drop_q   <= 1'b0;
      xphase_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      drop_q   <= drop_d;
      xphase_q <= xphase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bld_q  <= bld_d;
    size_q <= size_d;
    node_q <= node_d;
    k_q    <= k_d;
    v_q    <= v_d;
  end

  // heap memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  hse_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (out_push),
    .res_i           (out_res),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ----- hdl/hse_out_reg.sv -----
// output register stage that holds one sorted result until the master side takes it
module hse_out_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  hse_pkg::res_t             res_i,
  output logic                      free_o,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [hse_pkg::ValW-1:0]  m_axis_tdata_o,  // sorted_value
  output logic                      m_axis_tlast_o,
  output logic [0:0]                m_axis_tuser_o   // overflow
);
  import hse_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = res_q.value;
  assign m_axis_tlast_o  = res_q.last;
  assign m_axis_tuser_o  = res_q.overflow;

endmodule

// ----- tb/heap_sort_engine_test.sv -----
// testbench of the heap sort engine: directed and random runs with a sorting predictor and stream checks
`timescale 1ns / 100ps

module heap_sort_engine_test;

  import hse_pkg::*;

  localparam int unsigned RUN_CAP     = 64;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned DRAIN       = 200;
  localparam int unsigned RAND_ITEMS  = 200;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            last;
    logic            typed;
    logic [ValW-1:0] want_value;
    logic            want_last;
    logic            want_ovf;
  } dir_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_valid = 1'b0;
  logic [ValW-1:0] s_data = '0;
  logic            s_last = 1'b0;
  logic            m_ready = 1'b0;
  logic            s_axis_tready_o;
  logic            m_axis_tvalid_o;
  logic [ValW-1:0] m_axis_tdata_o;
  logic            m_axis_tlast_o;
  logic [0:0]      m_axis_tuser_o;

  logic signed [ValW-1:0] run_vals[$];
  logic                   run_dropped = 1'b0;
  res_t                   due_sorted[$];
  res_t                   want;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  bit          idle_on = 1'b0;
  bit          hold_req = 1'b0;

  dir_row_t dir_rows[19];

  heap_sort_engine #(.CAPACITY(RUN_CAP)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("heap_sort_engine_test: errors");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ValW-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return ValW'($signed($urandom_range(0, 7)) - 4);
      default: return $urandom();
    endcase
  endfunction

  // append one expected transaction
  task automatic queue_due(input res_t r);
    due_sorted.insert(due_sorted.size(), r);
  endtask

  // collect the run in ascending order, emit it on the last value
  task automatic take_value(input logic [ValW-1:0] raw, input logic is_last);
    logic signed [ValW-1:0] v;
    int                     j;
    v = raw;
    if (run_vals.size() < RUN_CAP) begin
      j = 0;
      while (j < run_vals.size() && run_vals[j] <= v) j++;
      run_vals.insert(j, v);
    end else begin
      run_dropped = 1'b1;
    end
    if (is_last) begin
      foreach (run_vals[k])
        queue_due('{overflow: run_dropped,
                    last: (k == run_vals.size() - 1),
                    value: run_vals[k]});
      run_vals.delete();
      run_dropped = 1'b0;
    end
  endtask

  task automatic offer(input logic [ValW-1:0] v, input logic is_last);
    int unsigned gap;
    gap = idle_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= v;
    s_last  <= is_last;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready_o) break;
    end
    items_sent++;
  endtask

  task automatic send_run(input int unsigned len);
    logic [ValW-1:0] v;
    for (int unsigned i = 0; i < len; i++) begin
      v = rand_value();
      offer(v, i == len - 1);
      take_value(v, i == len - 1);
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [ValW-1:0] exp_v,
                               input logic [ValW-1:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h at cycle %0d",
               field, exp_v, got_v, cycle_count);
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      stall_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end else if (stall_left == 0) begin
      stall_left = idle_gap();
    end
    if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left--;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (due_sorted.size() == 0) begin
        flag_mismatch("unexpected transaction", '0, m_axis_tdata_o);
      end else begin
        want = due_sorted.pop_front();
        if (m_axis_tdata_o !== want.value)
          flag_mismatch("sorted_value", want.value, m_axis_tdata_o);
        if (m_axis_tlast_o !== want.last)
          flag_mismatch("last", ValW'(want.last), ValW'(m_axis_tlast_o));
        if (m_axis_tuser_o[0] !== want.overflow)
          flag_mismatch("overflow", ValW'(want.overflow), ValW'(m_axis_tuser_o[0]));
      end
    end
  end

  initial begin
    dir_rows = '{
      // single-value runs: the extremes, zero and minus one, straight after reset
      '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0},
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
      // mixed signs with a repeated value
      '{32'h0000_0005, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'hFFFF_FFFD, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'h0000_0005, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0, '0, 1'b0, 1'b0},
      // two values, descending
      '{32'h0000_0001, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'h8000_0001, 1'b1, 1'b0, '0, 1'b0, 1'b0},
      // all equal
      '{32'hFFFF_FFFE, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'hFFFF_FFFE, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'hFFFF_FFFE, 1'b1, 1'b0, '0, 1'b0, 1'b0},
      // already ascending
      '{32'h8000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'h5555_5555, 1'b0, 1'b0, '0, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1'b0, '0, 1'b0, 1'b0}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_on = 1'b0;
    foreach (dir_rows[k]) begin
      offer(dir_rows[k].value, dir_rows[k].last);
      if (dir_rows[k].typed)
        queue_due('{overflow: dir_rows[k].want_ovf,
                    last: dir_rows[k].want_last,
                    value: dir_rows[k].want_value});
      else
        take_value(dir_rows[k].value, dir_rows[k].last);
    end

    items_sent = 0;
    idle_on = 1'b1;
    send_run(RUN_CAP + $urandom_range(1, 4));
    send_run(RUN_CAP);
    // long output stall while further runs keep coming
    hold_req = 1'b1;
    send_run(5);
    send_run(3);
    send_run(7);
    while (items_sent < RAND_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0)
        send_run($urandom_range(2, 20));
      else
        send_run($urandom_range(1, 10));
    end
    @(negedge clk_i);
    s_valid <= 1'b0;

    while (due_sorted.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("heap_sort_engine_test: clean");
    end else begin
      $display("heap_sort_engine_test: errors");
    end
    $finish;
  end

endmodule
